### rtl/core/tmsf_pkg.sv
package tmsf_pkg;

  // window geometry
  localparam int WINDOW   = 20;
  localparam int TRIM     = 3;
  localparam int CHANNELS = 4;

  // field widths
  localparam int CH_W     = 2;
  localparam int SAMPLE_W = 16;
  localparam int TDATA_W  = 24;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  // values left after trimming; a window trimmed to nothing gives zero
  localparam bit HAS_KEPT = (WINDOW > 2 * TRIM);
  localparam int KEPT     = HAS_KEPT ? WINDOW - 2 * TRIM : 1;

  localparam int IDX_W  = $clog2(WINDOW);
  localparam int STEP_W = IDX_W + 1;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int ADDR_W = $clog2(CHANNELS * WINDOW);

  // sum of the kept values and its reciprocal scaling
  localparam int SUM_W   = SAMPLE_W + $clog2(KEPT);
  localparam int RECIP_W = SUM_W + 1;
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam longint RECIP = (longint'(1) << SUM_W) / KEPT;

  localparam logic [SAMPLE_W-1:0] VALUE_MASK = 16'hFFFC;

  // register word index (paddr[2])
  localparam logic REG_CALIBRATE = 1'b0;

  typedef logic [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic    ins;
    sample_t ins_data;
    logic    shift;
  } chain_ctrl_t;

  function automatic logic [ADDR_W-1:0] store_base(input logic [CH_W-1:0] ch);
    return ADDR_W'(int'(ch) * WINDOW);
  endfunction

endpackage

### rtl/core/tmsf_sort_cell.sv
module tmsf_sort_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              shift,
  input  logic              in_valid,
  input  tmsf_pkg::sample_t in_data,
  input  logic              nxt_full,
  input  tmsf_pkg::sample_t nxt_data,
  output logic              full,
  output tmsf_pkg::sample_t data,
  output logic              pass_valid,
  output tmsf_pkg::sample_t pass_data
);

  logic in_lower;

  assign in_lower = in_data < data;

  always_ff @(posedge clk) begin
    if (rst) begin
      full       <= 1'b0;
      pass_valid <= 1'b0;
    end else if (shift) begin
      full       <= nxt_full;
      pass_valid <= 1'b0;
    end else if (in_valid) begin
      full       <= 1'b1;
      pass_valid <= full;
    end else begin
      pass_valid <= 1'b0;
    end
  end

  // keep the smaller value, hand the larger one on
  always_ff @(posedge clk) begin
    if (shift) begin
      data <= nxt_data;
    end else if (in_valid) begin
      if (!full || in_lower) begin
        data <= in_data;
      end
      pass_data <= in_lower ? data : in_data;
    end
  end

endmodule

### rtl/core/tmsf_sort_chain.sv
module tmsf_sort_chain (
  input  logic                  clk,
  input  logic                  rst,
  input  tmsf_pkg::chain_ctrl_t ctrl,
  output tmsf_pkg::sample_t     head
);
  import tmsf_pkg::*;

  logic [WINDOW-1:0] full;
  logic [WINDOW-1:0] pv;
  sample_t           data [WINDOW];
  sample_t           pd   [WINDOW];

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    logic    cv;
    sample_t cd;
    logic    nf;
    sample_t nd;

    if (i == 0) begin : g_first
      assign cv = ctrl.ins;
      assign cd = ctrl.ins_data;
    end else begin : g_mid
      assign cv = pv[i-1];
      assign cd = pd[i-1];
    end

    if (i == WINDOW - 1) begin : g_last
      assign nf = 1'b0;
      assign nd = '0;
    end else begin : g_inner
      assign nf = full[i+1];
      assign nd = data[i+1];
    end

    tmsf_sort_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .shift      (ctrl.shift),
      .in_valid   (cv),
      .in_data    (cd),
      .nxt_full   (nf),
      .nxt_data   (nd),
      .full       (full[i]),
      .data       (data[i]),
      .pass_valid (pv[i]),
      .pass_data  (pd[i])
    );
  end

  // smallest value sits in the first cell
  assign head = data[0];

endmodule

### rtl/core/tmsf_mean_div.sv
module tmsf_mean_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [tmsf_pkg::SUM_W-1:0]   sum,
  output logic                         done,
  output tmsf_pkg::sample_t            mean
);
  import tmsf_pkg::*;

  logic              v1, v2, v3;
  logic [SUM_W-1:0]  sum_q;
  logic [PROD_W-1:0] prod1;
  logic [SUM_W-1:0]  q0;
  logic [SUM_W-1:0]  prod2;
  logic [SUM_W-1:0]  rem;

  assign rem = sum_q - prod2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start;
      v2   <= v1;
      v3   <= v2;
      done <= v3;
    end
  end

  // reciprocal estimate, at most one short, then one correction step
  always_ff @(posedge clk) begin
    if (start) begin
      sum_q <= sum;
      prod1 <= PROD_W'(sum) * PROD_W'(RECIP);
    end
    if (v1) begin
      q0 <= prod1[SUM_W +: SUM_W];
    end
    if (v2) begin
      prod2 <= SUM_W'(q0 * SUM_W'(KEPT));
    end
    if (v3) begin
      mean <= SAMPLE_W'(q0 + SUM_W'(rem >= SUM_W'(KEPT)));
    end
  end

endmodule

### rtl/core/trimmed_mean_sample_filter.sv
// a sample that does not complete a window is written to the store and counted; no item out
// calibration: the raw sample goes via res_value and ST_EMIT into the output register
// a sample that completes a window goes through these steps until its item is shown:
// reads from the store, the sort chain settling, drain with sum and write-back of the kept
// values, reciprocal divide; one item in work at a time
// reset (rst, synchronous): fill counts, calibrate and handshakes cleared; store not cleared
module trimmed_mean_sample_filter (
  input  logic                          clk,
  input  logic                          rst,
  // input items
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [tmsf_pkg::TDATA_W-1:0]  s_tdata,   // channel[1:0], sample[17:2], zero pad
  // result items
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [tmsf_pkg::TDATA_W-1:0]  m_tdata,   // out_channel[1:0], value[17:2], zero pad
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tmsf_pkg::PADDR_W-1:0]  paddr,
  input  logic [tmsf_pkg::PDATA_W-1:0]  pwdata,
  output logic [tmsf_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import tmsf_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SETTLE,
    ST_DRAIN,
    ST_DIVIDE,
    ST_EMIT
  } state_t;

  state_t             state;
  logic               calibrate;
  logic [CNT_W-1:0]   fill_count [2**CH_W];
  logic [CH_W-1:0]    ch_q;
  logic [STEP_W-1:0]  step;
  logic               rd_vld;
  logic [SUM_W-1:0]   sum;
  sample_t            res_value;
  logic               div_start;

  // input fields
  logic [CH_W-1:0]    in_channel;
  sample_t            in_sample;
  logic               in_fire;
  logic               in_ok;
  logic [CNT_W-1:0]   cnt_in;
  logic [CNT_W-1:0]   cnt_inc;
  logic               full_now;

  // sample store, one window per channel
  sample_t            store [CHANNELS*WINDOW];
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_wa;
  sample_t            mem_wd;
  logic [ADDR_W-1:0]  mem_ra;
  sample_t            mem_q;

  chain_ctrl_t        chain_ctrl;
  sample_t            head;
  logic               keep_step;
  logic               div_done;
  sample_t            mean;
  logic               cfg_write;

  assign in_channel = s_tdata[CH_W-1:0];
  assign in_sample  = s_tdata[CH_W +: SAMPLE_W];
  assign s_tready   = (state == ST_IDLE) && !rst;
  assign in_fire    = s_tvalid && s_tready;
  assign in_ok      = int'(in_channel) < CHANNELS;
  assign cnt_in     = fill_count[in_channel];
  assign cnt_inc    = cnt_in + CNT_W'(1);
  assign full_now   = (cnt_inc == CNT_W'(WINDOW));

  // sorted values leave the chain lowest first; the middle ones are kept
  assign keep_step = (step >= STEP_W'(TRIM)) && (step < STEP_W'(WINDOW - TRIM));

  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == REG_CALIBRATE) ? PDATA_W'(calibrate) : '0;

  // store port selection
  always_comb begin
    mem_we = 1'b0;
    mem_wa = store_base(ch_q) + ADDR_W'(step - STEP_W'(TRIM));
    mem_wd = head;
    case (state)
      ST_IDLE: begin
        mem_we = in_fire && !calibrate && in_ok;
        mem_wa = store_base(in_channel) + ADDR_W'(cnt_in);
        mem_wd = in_sample;
      end
      ST_DRAIN: begin
        mem_we = keep_step;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  assign mem_ra = store_base(ch_q) + ADDR_W'(step[IDX_W-1:0]);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_wa] <= mem_wd;
    end
    mem_q <= store[mem_ra];
  end

  // the window streams into the chain one value a cycle and comes out sorted
  assign chain_ctrl.ins      = rd_vld;
  assign chain_ctrl.ins_data = mem_q;
  assign chain_ctrl.shift    = (state == ST_DRAIN);

  tmsf_sort_chain u_chain (
    .clk  (clk),
    .rst  (rst),
    .ctrl (chain_ctrl),
    .head (head)
  );

  tmsf_mean_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .sum   (sum),
    .done  (div_done),
    .mean  (mean)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      calibrate <= 1'b0;
      rd_vld    <= 1'b0;
      div_start <= 1'b0;
      m_tvalid  <= 1'b0;
      for (int i = 0; i < 2**CH_W; i++) begin
        fill_count[i] <= '0;
      end
    end else begin
      rd_vld    <= (state == ST_LOAD);
      div_start <= 1'b0;

      if (cfg_write && (paddr[2] == REG_CALIBRATE)) begin
        calibrate <= pwdata[0];
      end

      // taken item leaves the output register unless a new one replaces it
      if (m_tvalid && m_tready && (state != ST_EMIT)) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            ch_q <= in_channel;
            if (calibrate) begin
              // raw pass-through, store untouched
              res_value <= in_sample;
              state     <= ST_EMIT;
            end else if (in_ok) begin
              if (full_now) begin
                step  <= '0;
                sum   <= '0;
                state <= ST_LOAD;
              end else begin
                fill_count[in_channel] <= cnt_inc;
              end
            end
          end
        end
        ST_LOAD: begin
          if (step == STEP_W'(WINDOW - 1)) begin
            step  <= '0;
            state <= ST_SETTLE;
          end else begin
            step <= step + STEP_W'(1);
          end
        end
        ST_SETTLE: begin
          // last value still rippling down the chain
          if (step == STEP_W'(WINDOW)) begin
            step  <= '0;
            state <= ST_DRAIN;
          end else begin
            step <= step + STEP_W'(1);
          end
        end
        ST_DRAIN: begin
          if (keep_step) begin
            sum <= sum + SUM_W'(head);
          end
          step <= step + STEP_W'(1);
          if (step == STEP_W'(WINDOW - 1)) begin
            div_start <= 1'b1;
            state     <= ST_DIVIDE;
          end
        end
        ST_DIVIDE: begin
          if (div_done) begin
            res_value        <= HAS_KEPT ? (mean & VALUE_MASK) : '0;
            fill_count[ch_q] <= HAS_KEPT ? CNT_W'(KEPT) : '0;
            state            <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          // wait for the output register to free up
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= TDATA_W'({res_value, ch_q});
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/core/tmsf_check.sv
module tmsf_check (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic [tmsf_pkg::TDATA_W-1:0]  s_tdata,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [tmsf_pkg::TDATA_W-1:0]  m_tdata,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [tmsf_pkg::PADDR_W-1:0]  paddr,
  input logic [tmsf_pkg::PDATA_W-1:0]  pwdata,
  input logic [tmsf_pkg::PDATA_W-1:0]  prdata,
  input logic                          pready
);
  import tmsf_pkg::*;

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result item changed while stalled");

  // padding above the value stays clear
  a_out_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[TDATA_W-1:CH_W+SAMPLE_W] == '0)
    else $error("result padding not zero");

  // reset empties the output register
  a_rst_out: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result item shown after reset");

  // the calibrate register reads back as a single bit
  a_reg_read: assert property (@(posedge clk) disable iff (rst)
    pready && (paddr[2] == REG_CALIBRATE) |-> prdata[PDATA_W-1:1] == '0)
    else $error("register read carries stray bits");

endmodule

bind trimmed_mean_sample_filter tmsf_check u_tmsf_check (.*);
